// File: sv/rpmc_pkg.sv
package rpmc_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_WALL_DEPTH = 2048;

	// cell state codes
	localparam logic [1:0] ST_PATH = 2'd0;
	localparam logic [1:0] ST_WALL = 2'd1;
	localparam logic [1:0] ST_VISITED = 2'd2;

	// directions
	localparam logic [1:0] DIR_WEST = 2'd0;
	localparam logic [1:0] DIR_NORTH = 2'd1;
	localparam logic [1:0] DIR_EAST = 2'd2;
	localparam logic [1:0] DIR_SOUTH = 2'd3;

	// config register indexes
	localparam logic [1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [1:0] REG_NUM_COLS = 2'd1;
	localparam logic [1:0] REG_START_ROW = 2'd2;
	localparam logic [1:0] REG_START_COL = 2'd3;

	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLEAR,
		S_START,
		S_MOD,
		S_LREAD,
		S_LWAIT,
		S_NREAD,
		S_NWAIT,
		S_CARVE,
		S_SWAP,
		S_SWAPW,
		S_PREAD,
		S_PWAIT,
		S_PNEXT,
		S_FIN
	} state_t;

endpackage

// File: sv/random_prim_maze_carver_top.sv
// Randomized Prim maze carver. A word is taken when start is high and busy is
// low; busy stays high until the cycle of the result strobe done, which
// carries the one result word of the item. The receiver cannot stall: the
// result is on the ports for that single cycle only. Restart (opcode 0) sweeps
// the grid memory one cell per cycle, then marks the start cell and examines
// its four neighbors. A step (opcode 1) first computes the remainder (one
// quotient bit per cycle), then reads the picked entry, the last entry and
// the cell beyond the wall, and when a cell is carved its walls are pushed.
// A step on an empty list skips the division and the reads. The memories are
// single port with a registered read, which sets the sequence.
module random_prim_maze_carver_top #(
	parameter int MAX_ROWS = rpmc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = rpmc_pkg::DEF_MAX_COLS,
	parameter int WALL_LIST_DEPTH = rpmc_pkg::DEF_WALL_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] random_pick,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	output logic        done,
	output logic        done_res,
	output logic        carved,
	output logic [5:0]  wall_row,
	output logic [5:0]  wall_col,
	output logic [5:0]  cell_row,
	output logic [5:0]  cell_col,
	output logic [11:0] walls_pending
);
	import rpmc_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int GRID = MAX_ROWS * MAX_COLS;
	localparam int GW = $clog2(GRID);
	localparam int LW = (WALL_LIST_DEPTH > 1) ? $clog2(WALL_LIST_DEPTH) : 1;
	localparam int NW = $clog2(WALL_LIST_DEPTH + 1);
	localparam int EW = RW + CW + 2;

	// configuration
	logic [6:0] num_rows_q, num_cols_q;
	logic [5:0] start_row_q, start_col_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 7'd63;
			num_cols_q <= 7'd63;
			start_row_q <= 6'd1;
			start_col_q <= 6'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				REG_NUM_COLS: num_cols_q <= cfg_data;
				REG_START_ROW: start_row_q <= cfg_data[5:0];
				REG_START_COL: start_col_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// effective bounds, clamped to the build size
	logic [8:0] rows_used, cols_used;
	assign rows_used = ({2'b0, num_rows_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, num_rows_q};
	assign cols_used = ({2'b0, num_cols_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, num_cols_q};

	// grid memory: cell state plus processed flag
	logic [2:0] grid_mem [GRID];
	logic       g_we;
	logic [GW-1:0] g_addr;
	logic [2:0] g_wdata, g_rdata;
	always_ff @(posedge clk) begin
		if (g_we) grid_mem[g_addr] <= g_wdata;
		g_rdata <= grid_mem[g_addr];
	end

	// wall list memory
	logic [EW-1:0] list_mem [WALL_LIST_DEPTH];
	logic          l_we;
	logic [LW-1:0] l_addr;
	logic [EW-1:0] l_wdata, l_rdata;
	always_ff @(posedge clk) begin
		if (l_we) list_mem[l_addr] <= l_wdata;
		l_rdata <= list_mem[l_addr];
	end

	state_t state_q, state_d;
	logic [GW:0]   clr_q;
	logic [RW-1:0] clr_r_q;
	logic [CW-1:0] clr_c_q;
	logic [NW-1:0] count_q;
	logic          op_q;
	logic [16:0]   rem_q;
	logic [15:0]   quo_q;
	logic [4:0]    bit_q;
	logic [LW-1:0] idx_q;
	logic [EW-1:0] ent_q, last_q;
	logic [RW+1:0] cr_q;
	logic [CW+1:0] cc_q;
	logic [2:0]    dir_q;
	logic [9:0]    pr, pc;
	logic          carved_q;
	logic          fin_empty_q;

	// coordinates of the picked wall and the cell beyond it
	logic [RW-1:0] e_r;
	logic [CW-1:0] e_c;
	logic [1:0]    e_d;
	assign e_r = ent_q[EW-1 -: RW];
	assign e_c = ent_q[CW+1:2];
	assign e_d = ent_q[1:0];

	logic [9:0] nr, nc;
	always_comb begin
		nr = 10'(e_r);
		nc = 10'(e_c);
		unique case (e_d)
			DIR_WEST: nc = 10'(e_c) - 10'd1;
			DIR_NORTH: nr = 10'(e_r) - 10'd1;
			DIR_EAST: nc = 10'(e_c) + 10'd1;
			DIR_SOUTH: nr = 10'(e_r) + 10'd1;
			default: ;
		endcase
	end
	logic n_in;
	assign n_in = !nr[9] && !nc[9] && (nr < 10'(rows_used)) && (nc < 10'(cols_used));

	// neighbor under push examination
	always_comb begin
		pr = {2'b0, cr_q[RW+1:0]} ;
		pc = {2'b0, cc_q[CW+1:0]};
		unique case (dir_q[1:0])
			DIR_WEST: pc = 10'(cc_q) - 10'd1;
			DIR_NORTH: pr = 10'(cr_q) - 10'd1;
			DIR_EAST: pc = 10'(cc_q) + 10'd1;
			DIR_SOUTH: pr = 10'(cr_q) + 10'd1;
			default: ;
		endcase
	end
	logic p_in;
	assign p_in = !pr[9] && !pc[9] && (pr < 10'(rows_used)) && (pc < 10'(cols_used));

	logic [GW-1:0] clr_addr;
	assign clr_addr = clr_q[GW-1:0];

	logic [5:0] sr, sc;
	assign sr = start_row_q | 6'd1;
	assign sc = start_col_q | 6'd1;

	logic [16:0] rem_sh;
	assign rem_sh = {rem_q[15:0], quo_q[15]};

	// sequencer
	always_comb begin
		state_d = state_q;
		g_we = 1'b0;
		g_addr = '0;
		g_wdata = '0;
		l_we = 1'b0;
		l_addr = '0;
		l_wdata = '0;
		unique case (state_q)
			S_IDLE: if (start) state_d = (opcode == OP_RESTART) ? S_CLEAR : S_MOD;
			S_CLEAR: begin
				g_we = 1'b1;
				g_addr = clr_addr;
				g_wdata = {1'b0, (!clr_r_q[0] || !clr_c_q[0]) ? ST_WALL : ST_PATH};
				if (clr_q == (GW+1)'(GRID - 1)) state_d = S_START;
			end
			S_START: begin
				if ((9'(sr) < rows_used) && (9'(sc) < cols_used)) begin
					g_we = 1'b1;
					g_addr = GW'(32'(sr) * MAX_COLS + 32'(sc));
					g_wdata = {1'b0, ST_VISITED};
					state_d = S_PREAD;
				end else state_d = S_FIN;
			end
			S_MOD: begin
				if (count_q == '0) state_d = S_FIN;
				else if (bit_q == 5'd16) state_d = S_LREAD;
			end
			S_LREAD: begin
				l_addr = idx_q;
				state_d = S_LWAIT;
			end
			S_LWAIT: begin
				l_addr = LW'(count_q - NW'(1));
				state_d = S_NREAD;
			end
			S_NREAD: begin
				g_addr = GW'(32'(nr[RW-1:0]) * MAX_COLS + 32'(nc[CW-1:0]));
				state_d = n_in ? S_NWAIT : S_SWAP;
			end
			S_NWAIT: state_d = (g_rdata[1:0] == ST_PATH) ? S_CARVE : S_SWAP;
			S_CARVE: begin
				g_we = 1'b1;
				g_addr = GW'(32'(e_r) * MAX_COLS + 32'(e_c));
				g_wdata = {1'b1, ST_VISITED};
				state_d = S_SWAPW;
			end
			S_SWAPW: begin
				g_we = 1'b1;
				g_addr = GW'(32'(cr_q) * MAX_COLS + 32'(cc_q));
				g_wdata = {1'b0, ST_VISITED};
				state_d = S_PREAD;
			end
			S_SWAP: begin
				// last entry is re-read after pushes, else taken from the early read
				l_we = 1'b1;
				l_addr = idx_q;
				l_wdata = carved_q ? l_rdata : last_q;
				state_d = S_FIN;
			end
			S_PREAD: begin
				if (dir_q[2]) begin
					if (op_q == OP_STEP) begin
						l_addr = LW'(count_q - NW'(1));
						state_d = S_SWAP;
					end else state_d = S_FIN;
				end else if (!p_in) state_d = S_PNEXT;
				else begin
					g_addr = GW'(32'(pr[RW-1:0]) * MAX_COLS + 32'(pc[CW-1:0]));
					state_d = S_PWAIT;
				end
			end
			S_PWAIT: begin
				g_addr = GW'(32'(pr[RW-1:0]) * MAX_COLS + 32'(pc[CW-1:0]));
				if (g_rdata[1:0] == ST_WALL && !g_rdata[2] &&
						count_q < NW'(WALL_LIST_DEPTH)) begin
					g_we = 1'b1;
					g_wdata = {1'b1, g_rdata[1:0]};
					l_we = 1'b1;
					l_addr = LW'(count_q);
					l_wdata = {pr[RW-1:0], pc[CW-1:0], dir_q[1:0]};
				end
				state_d = S_PNEXT;
			end
			S_PNEXT: state_d = S_PREAD;
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers; a carved cell's walls are pushed first, then the
	// picked entry is replaced by whatever is last at that point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			clr_q <= '0;
			clr_r_q <= '0;
			clr_c_q <= '0;
			bit_q <= '0;
			dir_q <= '0;
			carved_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					clr_q <= '0;
					clr_r_q <= '0;
					clr_c_q <= '0;
					bit_q <= '0;
					carved_q <= 1'b0;
					dir_q <= '0;
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					// row and column of the sweep, wrapping at the grid width
					if (clr_c_q == CW'(MAX_COLS - 1)) begin
						clr_c_q <= '0;
						clr_r_q <= clr_r_q + 1'b1;
					end else clr_c_q <= clr_c_q + 1'b1;
					if (state_d == S_START) count_q <= '0;
				end
				S_MOD: if (count_q != '0) bit_q <= bit_q + 5'd1;
				S_NWAIT: carved_q <= (g_rdata[1:0] == ST_PATH);
				S_SWAP: begin
					count_q <= count_q - NW'(1);
					dir_q <= '0;
				end
				S_PWAIT: if (l_we) count_q <= count_q + NW'(1);
				S_PNEXT: dir_q <= dir_q + 3'd1;
				S_FIN: done <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q <= opcode;
				quo_q <= random_pick;
				rem_q <= '0;
			end
			S_START: begin
				cr_q <= (RW+2)'(sr);
				cc_q <= (CW+2)'(sc);
			end
			S_MOD: if (bit_q != 5'd16) begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= 17'(count_q)) rem_q <= rem_sh - 17'(count_q);
				else rem_q <= rem_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end else idx_q <= LW'(rem_q);
			S_LWAIT: ent_q <= l_rdata;
			S_NREAD: begin
				last_q <= l_rdata;
				cr_q <= (RW+2)'(nr);
				cc_q <= (CW+2)'(nc);
			end
			default: ;
		endcase
	end

	// result fields
	assign busy = (state_q != S_IDLE);
	assign done_res = op_q && (count_q == '0) && !carved_q && (state_q == S_IDLE) && fin_empty_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_empty_q <= 1'b0;
		else if (state_q == S_MOD && bit_q == 5'd0) fin_empty_q <= (count_q == '0);
		else if (state_q == S_IDLE && start) fin_empty_q <= 1'b0;
	end
	logic stepped;
	assign stepped = op_q && !fin_empty_q;
	assign carved = carved_q;
	assign wall_row = stepped ? 6'(e_r) : 6'd0;
	assign wall_col = stepped ? 6'(e_c) : 6'd0;
	assign cell_row = carved_q ? 6'(cr_q) : 6'd0;
	assign cell_col = carved_q ? 6'(cc_q) : 6'd0;
	assign walls_pending = 12'(count_q);

endmodule
